// ===== src/stk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted top-k score table.
// No dependencies; the controller, datapath and top level import this package.
package stk_pkg;

    // Reset value of the capacity register
    localparam logic [4:0] CAP_RESET = 5'd10;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_REPORT   = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_REPORTED  = 3'd4,
        ST_BAD_INDEX = 3'd5,
        ST_NO_MATCH  = 3'd6
    } status_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_DECIDE,
        S_SHIFT_DOWN,
        S_WRITE_NEW,
        S_REM_FIRST,
        S_REM_SHIFT,
        S_REP_SCAN,
        S_FINISH
    } state_e;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        player_key;
        logic signed [31:0] new_score;
        logic [7:0]         slot_index;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         position;
        logic [15:0]        out_key;
        logic signed [31:0] out_score;
        logic [4:0]         entry_count;
        logic               last;
    } rsp_t;

    typedef logic [4:0] cap_t;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [15:0]        key;
        logic signed [31:0] score;
    } entry_t;

    // Strobes from the controller, one per datapath step
    typedef struct packed {
        logic load;
        logic add_scan;
        logic add_decide;
        logic shift_down;
        logic write_new;
        logic rem_first;
        logic rem_shift;
        logic rep_scan;
        logic finish;
    } stk_ctl_t;

    // Conditions reported by the datapath
    typedef struct packed {
        cmd_e cmd;
        logic cnt_zero;
        logic bad_index;
        logic scan_last;
        logic ignore;
        logic shift_more;
        logic shift_done;
        logic rem_more;
        logic rem_done;
        logic stall;
        logic out_free;
    } stk_sts_t;

endpackage

// ===== src/stk_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// Payload type is set at instantiation; no package dependency.
interface stk_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/stk_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the score table: walks one command through its steps.
// Depends on stk_pkg for the state, strobe and status types.
module stk_ctrl
    import stk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  stk_sts_t sts,
    output stk_ctl_t ctl
);

    state_e state_reg;
    state_e state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (sts.cmd)
                        CMD_ADD:    state_next = sts.cnt_zero ? S_ADD_DECIDE : S_ADD_SCAN;
                        CMD_REMOVE: state_next = sts.bad_index ? S_FINISH : S_REM_FIRST;
                        CMD_REPORT: state_next = sts.cnt_zero ? S_FINISH : S_REP_SCAN;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_ADD_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_ADD_DECIDE;
                end
            end
            S_ADD_DECIDE:
            begin
                if (sts.ignore)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.shift_more)
                begin
                    state_next = S_SHIFT_DOWN;
                end
                else
                begin
                    state_next = S_WRITE_NEW;
                end
            end
            S_SHIFT_DOWN:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_WRITE_NEW;
                end
            end
            S_WRITE_NEW:
            begin
                state_next = S_FINISH;
            end
            S_REM_FIRST:
            begin
                state_next = sts.rem_more ? S_REM_SHIFT : S_FINISH;
            end
            S_REM_SHIFT:
            begin
                if (sts.rem_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_REP_SCAN:
            begin
                if (!sts.stall && sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: one datapath strobe per state
    always_comb
    begin
        req_ready = 1'b0;
        ctl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                ctl.load  = req_valid;
            end
            S_ADD_SCAN:   ctl.add_scan   = 1'b1;
            S_ADD_DECIDE: ctl.add_decide = 1'b1;
            S_SHIFT_DOWN: ctl.shift_down = 1'b1;
            S_WRITE_NEW:  ctl.write_new  = 1'b1;
            S_REM_FIRST:  ctl.rem_first  = 1'b1;
            S_REM_SHIFT:  ctl.rem_shift  = 1'b1;
            S_REP_SCAN:   ctl.rep_scan   = 1'b1;
            S_FINISH:     ctl.finish     = 1'b1;
            default:      ctl            = '0;
        endcase
    end

endmodule

// ===== src/stk_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the score table: entry memory, count, capacity, scan
// pointer, result staging and output register. Depends on stk_pkg.
module stk_dpath
    import stk_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  stk_ctl_t ctl,
    output stk_sts_t sts,
    input  req_t     req_data,
    input  logic     cfg_valid,
    input  cap_t     cfg_data,
    input  logic     rsp_ready,
    output logic     rsp_valid,
    output rsp_t     rsp_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Entry memory, one write and one registered read per cycle
    entry_t entry_mem [DEPTH];
    entry_t rd_entry_reg;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;

    // Control state
    cap_t          cap_reg,       cap_next;
    logic [CW-1:0] count_reg,     count_next;
    logic          out_valid_reg, out_valid_next;

    // Per-command working registers
    logic [15:0]        key_reg,   key_next;
    logic signed [31:0] score_reg, score_next;
    logic signed [31:0] lo_reg,    lo_next;
    logic signed [31:0] hi_reg,    hi_next;
    logic [AW-1:0]      ptr_reg,   ptr_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      idx_reg,   idx_next;
    logic signed [31:0] old_reg,   old_next;
    logic signed [31:0] last_reg,  last_next;
    logic [CW-1:0]      ge_reg,    ge_next;
    logic [AW-1:0]      pos_reg,   pos_next;
    logic               upd_reg,   upd_next;
    logic               pend_reg,  pend_next;

    // Staged result
    status_e            res_status_reg, res_status_next;
    logic [AW-1:0]      res_pos_reg,    res_pos_next;
    logic [15:0]        res_key_reg,    res_key_next;
    logic signed [31:0] res_score_reg,  res_score_next;

    rsp_t out_data_reg, out_data_next;

    logic [CW-1:0] eff_cap;
    logic          full;
    logic [AW-1:0] top;
    logic [AW-1:0] ins_pos;
    logic          match;
    logic          hit;
    logic          push;
    logic          push_last;

    // Clamp capacity to one through DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            eff_cap = CW'(DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    // Conditions for the controller
    assign full    = (count_reg >= eff_cap);
    assign top     = found_reg ? idx_reg : (full ? AW'(count_reg - 1'b1) : AW'(count_reg));
    assign ins_pos = AW'(ge_reg);
    assign match   = (rd_entry_reg.key == key_reg);
    assign hit     = ($signed(rd_entry_reg.score) >= lo_reg) &&
                     ($signed(rd_entry_reg.score) <= hi_reg);

    always_comb
    begin
        sts.cmd        = cmd_e'(req_data.command);
        sts.cnt_zero   = (count_reg == '0);
        sts.bad_index  = (32'(req_data.slot_index) >= 32'(count_reg));
        sts.scan_last  = ((32'(ptr_reg) + 32'd1) == 32'(count_reg));
        sts.ignore     = found_reg ? (score_reg < old_reg) : (full && (score_reg <= last_reg));
        sts.shift_more = (top > ins_pos);
        sts.shift_done = (ptr_reg == pos_reg);
        sts.rem_more   = ((32'(ptr_reg) + 32'd1) < 32'(count_reg));
        sts.rem_done   = (32'(ptr_reg) == 32'(count_reg));
        sts.stall      = hit && pend_reg && out_valid_reg && !rsp_ready;
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    // Step actions
    always_comb
    begin
        cap_next        = cap_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        score_next      = score_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        old_next        = old_reg;
        last_next       = last_reg;
        ge_next         = ge_reg;
        pos_next        = pos_reg;
        upd_next        = upd_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_key_next    = res_key_reg;
        res_score_next  = res_score_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        push            = 1'b0;
        push_last       = 1'b0;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        // Latch the item and start its first read
        if (ctl.load)
        begin
            key_next   = req_data.player_key;
            score_next = req_data.new_score;
            lo_next    = req_data.range_low;
            hi_next    = req_data.range_high;
            ptr_next   = '0;
            found_next = 1'b0;
            ge_next    = '0;
            pend_next  = 1'b0;
            case (sts.cmd)
                CMD_ADD:
                begin
                    mem_re = !sts.cnt_zero;
                end
                CMD_REMOVE:
                begin
                    if (sts.bad_index)
                    begin
                        res_status_next = ST_BAD_INDEX;
                        res_pos_next    = '0;
                        res_key_next    = '0;
                        res_score_next  = '0;
                    end
                    else
                    begin
                        ptr_next  = AW'(req_data.slot_index);
                        mem_re    = 1'b1;
                        mem_raddr = AW'(req_data.slot_index);
                    end
                end
                CMD_REPORT:
                begin
                    res_status_next = ST_NO_MATCH;
                    res_pos_next    = '0;
                    res_key_next    = '0;
                    res_score_next  = '0;
                    mem_re          = !sts.cnt_zero;
                end
                default:
                begin
                    res_status_next = ST_IGNORED;
                    res_pos_next    = '0;
                    res_key_next    = '0;
                    res_score_next  = '0;
                end
            endcase
        end

        // Look for the key and count entries that stay ahead of the new score
        if (ctl.add_scan)
        begin
            if (match && !found_reg)
            begin
                found_next = 1'b1;
                idx_next   = ptr_reg;
                old_next   = rd_entry_reg.score;
            end
            else if (!found_reg && ($signed(rd_entry_reg.score) >= score_reg))
            begin
                ge_next = ge_reg + 1'b1;
            end
            if (sts.scan_last)
            begin
                last_next = rd_entry_reg.score;
            end
            else
            begin
                ptr_next  = ptr_reg + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_reg + 1'b1;
            end
        end

        // Choose between drop, update and insert
        if (ctl.add_decide)
        begin
            if (sts.ignore)
            begin
                res_status_next = ST_IGNORED;
                res_pos_next    = '0;
                res_key_next    = key_reg;
                res_score_next  = score_reg;
            end
            else
            begin
                pos_next = ins_pos;
                upd_next = found_reg;
                if (!found_reg && !full)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (sts.shift_more)
                begin
                    ptr_next  = top - 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = top - 1'b1;
                end
            end
        end

        // Move entries one place back to open the target slot
        if (ctl.shift_down)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg + 1'b1;
            mem_wdata = rd_entry_reg;
            if (!sts.shift_done)
            begin
                ptr_next  = ptr_reg - 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_reg - 1'b1;
            end
        end

        if (ctl.write_new)
        begin
            mem_we          = 1'b1;
            mem_waddr       = pos_reg;
            mem_wdata.key   = key_reg;
            mem_wdata.score = score_reg;
            res_status_next = upd_reg ? ST_UPDATED : ST_INSERTED;
            res_pos_next    = pos_reg;
            res_key_next    = key_reg;
            res_score_next  = score_reg;
        end

        // Capture the removed entry
        if (ctl.rem_first)
        begin
            res_status_next = ST_REMOVED;
            res_pos_next    = ptr_reg;
            res_key_next    = rd_entry_reg.key;
            res_score_next  = rd_entry_reg.score;
            count_next      = count_reg - 1'b1;
            if (sts.rem_more)
            begin
                ptr_next  = ptr_reg + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_reg + 1'b1;
            end
        end

        // Close the gap, one entry forward per cycle
        if (ctl.rem_shift)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg - 1'b1;
            mem_wdata = rd_entry_reg;
            if (!sts.rem_done)
            begin
                ptr_next  = ptr_reg + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_reg + 1'b1;
            end
        end

        // Hold one match back so the final one can carry last
        if (ctl.rep_scan && !sts.stall)
        begin
            if (hit)
            begin
                push            = pend_reg;
                pend_next       = 1'b1;
                res_status_next = ST_REPORTED;
                res_pos_next    = ptr_reg;
                res_key_next    = rd_entry_reg.key;
                res_score_next  = rd_entry_reg.score;
            end
            if (!sts.scan_last)
            begin
                ptr_next  = ptr_reg + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = ptr_reg + 1'b1;
            end
        end

        if (ctl.finish && sts.out_free)
        begin
            push      = 1'b1;
            push_last = 1'b1;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push)
        begin
            out_valid_next            = 1'b1;
            out_data_next.status      = res_status_reg;
            out_data_next.position    = 4'(res_pos_reg);
            out_data_next.out_key     = res_key_reg;
            out_data_next.out_score   = res_score_reg;
            out_data_next.entry_count = 5'(count_next);
            out_data_next.last        = push_last;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        score_reg      <= score_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        ptr_reg        <= ptr_next;
        found_reg      <= found_next;
        idx_reg        <= idx_next;
        old_reg        <= old_next;
        last_reg       <= last_next;
        ge_reg         <= ge_next;
        pos_reg        <= pos_next;
        upd_reg        <= upd_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_key_reg    <= res_key_next;
        res_score_reg  <= res_score_next;
        out_data_reg   <= out_data_next;
    end

    // Entry memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_entry_reg <= entry_mem[mem_raddr];
        end
    end

endmodule

// ===== src/sorted_top_k_score_table.sv =====
`timescale 1ns / 1ps
// Sorted top-k score table: keys kept in descending score order.
// Usage:
//   req carries one command item (add/update, remove by index, report range).
//   rsp returns result items; the last one of a command has last set.
//   cfg writes the capacity register; write it only while the table is idle.
// Steps, with n entries in use: an add scans the n entries, shifts entries
// back as needed to open its slot and writes it; an add to an empty table
// skips the scan, and a dropped add skips the shift and write. A remove moves
// each later entry forward; a bad index goes straight to the result. A report
// scans the n entries and can pause while the receiver stalls. The entry
// memory, one entry read and one written per cycle, sets the pace.
// One command is worked at a time; req is ready again once the final result
// sits in the output register, so the next command starts while it waits.
// A stalled receiver holds the output register; a report then pauses its
// scan at a further match until the register frees up.
// Reset empties the table and sets capacity to 10; entry storage itself is
// not cleared, since only entries below the count are ever read.
module sorted_top_k_score_table
    import stk_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    stk_chan_if.sink   req,
    stk_chan_if.source rsp,
    stk_chan_if.sink   cfg
);

    stk_ctl_t ctl;
    stk_sts_t sts;

    // Capacity writes are always taken
    assign cfg.ready = 1'b1;

    stk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    stk_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .req_data  (req.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

endmodule
